// ===== hdl/i2crts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crts_pkg
// Shared types and codes for the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
package i2crts_pkg;

  localparam logic [1:0] OP_START_READ  = 2'd0;
  localparam logic [1:0] OP_START_WRITE = 2'd1;
  localparam logic [1:0] OP_WRITE_BYTE  = 2'd2;
  localparam logic [1:0] OP_XFER_DONE   = 2'd3;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CHIP   = 3'd1;
  localparam logic [2:0] PH_ADDR   = 3'd2;
  localparam logic [2:0] PH_RSTART = 3'd3;
  localparam logic [2:0] PH_READ   = 3'd4;
  localparam logic [2:0] PH_WANT   = 3'd5;
  localparam logic [2:0] PH_WDATA  = 3'd6;

  localparam logic [1:0] COND_NORMAL = 2'd0;
  localparam logic [1:0] COND_START  = 2'd1;
  localparam logic [1:0] COND_STOP   = 2'd2;

  localparam logic [1:0] AK_WAIT = 2'd0;
  localparam logic [1:0] AK_ACK  = 2'd1;
  localparam logic [1:0] AK_NAK  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_READ  = 2'd1;
  localparam logic [1:0] ST_BYTE_FAIL  = 2'd2;
  localparam logic [1:0] ST_UNEXPECTED = 2'd3;

  localparam logic [2:0] MAX_ADDR_LEN = 3'd4;
  localparam logic [2:0] XFER_OK      = 3'd0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  chip;
    logic [31:0] mem_addr;
    logic [2:0]  addr_len;
    logic [15:0] byte_count;
    logic [7:0]  data;
    logic [2:0]  xfer_error;
  } req_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] cmd_condition;
    logic [1:0] cmd_acknack;
    logic       cmd_read;
    logic [7:0] cmd_data;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       want_data;
    logic       done_res;
    logic [1:0] status;
    logic [2:0] fail_code;
  } res_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [6:0]  target_chip;
    logic [31:0] register_address;
    logic [2:0]  addr_left;
    logic [15:0] data_left;
    logic        reading;
  } seq_state_t;

endpackage

// ===== hdl/i2crts_step.sv =====
// ----------------------------------------------------------------------------
// i2crts_step
// Next-state and result logic for one request against the sequencer state.
// ----------------------------------------------------------------------------
module i2crts_step (
  input  i2crts_pkg::seq_state_t state_i,
  input  i2crts_pkg::req_t       req_i,
  output i2crts_pkg::seq_state_t state_o,
  output i2crts_pkg::res_t       res_o
);

  logic        busy;
  logic        waiting;
  logic [1:0]  addr_idx;
  logic [15:0] left_dec;

  assign busy     = state_i.phase inside {[i2crts_pkg::PH_CHIP : i2crts_pkg::PH_WDATA]};
  assign waiting  = busy && (state_i.phase != i2crts_pkg::PH_WANT);
  assign addr_idx = 2'(state_i.addr_left - 3'd1);
  assign left_dec = state_i.data_left - 16'd1;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if ((req_i.opcode == i2crts_pkg::OP_START_READ ||
         req_i.opcode == i2crts_pkg::OP_START_WRITE) && !busy) begin
      if (req_i.opcode == i2crts_pkg::OP_START_READ && req_i.byte_count == 16'd0) begin
        res_o.done_res = 1'b1;
        res_o.status   = i2crts_pkg::ST_ZERO_READ;
        state_o.phase  = i2crts_pkg::PH_IDLE;
      end else begin
        state_o.target_chip      = req_i.chip;
        state_o.register_address = req_i.mem_addr;
        state_o.addr_left        = (req_i.addr_len > i2crts_pkg::MAX_ADDR_LEN) ?
                                   i2crts_pkg::MAX_ADDR_LEN : req_i.addr_len;
        state_o.data_left        = req_i.byte_count;
        state_o.reading          = (req_i.opcode == i2crts_pkg::OP_START_READ);
        res_o.cmd_valid          = 1'b1;
        res_o.cmd_condition      = i2crts_pkg::COND_START;
        res_o.cmd_acknack        = i2crts_pkg::AK_WAIT;
        res_o.cmd_data           = {req_i.chip, 1'b0};
        state_o.phase            = i2crts_pkg::PH_CHIP;
      end
    end else if (req_i.opcode == i2crts_pkg::OP_WRITE_BYTE &&
                 state_i.phase == i2crts_pkg::PH_WANT) begin
      res_o.cmd_valid     = 1'b1;
      res_o.cmd_condition = (state_i.data_left == 16'd1) ?
                            i2crts_pkg::COND_STOP : i2crts_pkg::COND_NORMAL;
      res_o.cmd_acknack   = i2crts_pkg::AK_WAIT;
      res_o.cmd_data      = req_i.data;
      state_o.data_left   = left_dec;
      state_o.phase       = i2crts_pkg::PH_WDATA;
    end else if (req_i.opcode == i2crts_pkg::OP_XFER_DONE && waiting) begin
      if (req_i.xfer_error != i2crts_pkg::XFER_OK) begin
        res_o.done_res  = 1'b1;
        res_o.status    = i2crts_pkg::ST_BYTE_FAIL;
        res_o.fail_code = req_i.xfer_error;
        state_o.phase   = i2crts_pkg::PH_IDLE;
      end else begin
        case (state_i.phase)
          i2crts_pkg::PH_CHIP, i2crts_pkg::PH_ADDR: begin
            if (state_i.addr_left != 3'd0) begin
              res_o.cmd_valid   = 1'b1;
              res_o.cmd_acknack = i2crts_pkg::AK_WAIT;
              res_o.cmd_data    = state_i.register_address[8*addr_idx +: 8];
              state_o.addr_left = state_i.addr_left - 3'd1;
              state_o.phase     = i2crts_pkg::PH_ADDR;
            end else if (state_i.reading) begin
              res_o.cmd_valid     = 1'b1;
              res_o.cmd_condition = i2crts_pkg::COND_START;
              res_o.cmd_data      = {state_i.target_chip, 1'b1};
              state_o.phase       = i2crts_pkg::PH_RSTART;
            end else if (state_i.data_left != 16'd0) begin
              res_o.want_data = 1'b1;
              state_o.phase   = i2crts_pkg::PH_WANT;
            end else begin
              res_o.done_res = 1'b1;
              state_o.phase  = i2crts_pkg::PH_IDLE;
            end
          end
          i2crts_pkg::PH_RSTART: begin
            res_o.cmd_valid = 1'b1;
            res_o.cmd_read  = 1'b1;
            if (state_i.data_left == 16'd1) begin
              res_o.cmd_condition = i2crts_pkg::COND_STOP;
              res_o.cmd_acknack   = i2crts_pkg::AK_NAK;
            end else begin
              res_o.cmd_acknack = i2crts_pkg::AK_ACK;
            end
            state_o.phase = i2crts_pkg::PH_READ;
          end
          i2crts_pkg::PH_READ: begin
            res_o.rx_valid    = 1'b1;
            res_o.rx_data     = req_i.data;
            state_o.data_left = left_dec;
            if (left_dec == 16'd0) begin
              res_o.done_res = 1'b1;
              state_o.phase  = i2crts_pkg::PH_IDLE;
            end else begin
              res_o.cmd_valid = 1'b1;
              res_o.cmd_read  = 1'b1;
              if (left_dec == 16'd1) begin
                res_o.cmd_condition = i2crts_pkg::COND_STOP;
                res_o.cmd_acknack   = i2crts_pkg::AK_NAK;
              end else begin
                res_o.cmd_acknack = i2crts_pkg::AK_ACK;
              end
              state_o.phase = i2crts_pkg::PH_READ;
            end
          end
          default: begin
            if (state_i.data_left != 16'd0) begin
              res_o.want_data = 1'b1;
              state_o.phase   = i2crts_pkg::PH_WANT;
            end else begin
              res_o.done_res = 1'b1;
              state_o.phase  = i2crts_pkg::PH_IDLE;
            end
          end
        endcase
      end
    end else begin
      if (!busy) begin
        state_o.phase = i2crts_pkg::PH_IDLE;
      end
      res_o.status = i2crts_pkg::ST_UNEXPECTED;
    end
  end

endmodule

// ===== hdl/i2c_register_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer
// Path: an accepted request is held in the input register, and its result is
// loaded into the result register when the output side can take it.
// Throughput: one request per cycle unless out_ready_i holds the result; the
// step logic lies between input and result registers; state loads with result.
// Reset: asynchronous, active low; state returns to idle with cleared fields.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2crts_pkg::req_t      in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2crts_pkg::res_t      out_res_o
);

  logic                   in_valid_q;
  i2crts_pkg::req_t       in_q;
  logic                   out_valid_q;
  i2crts_pkg::res_t       out_q;
  i2crts_pkg::seq_state_t state_q;
  i2crts_pkg::seq_state_t state_d;
  i2crts_pkg::res_t       res_d;
  logic                   advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  i2crts_step u_step (
    .state_i (state_q),
    .req_i   (in_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      state_q     <= state_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef SYNTHESIS
  a_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.cmd_valid |-> out_q.cmd_data == 8'd0 &&
      out_q.cmd_condition == i2crts_pkg::COND_NORMAL && !out_q.cmd_read)
    else $error("command fields set without a command");

  a_rx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.rx_valid |-> out_q.rx_data == 8'd0)
    else $error("rx data set without rx valid");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> state_q.phase == i2crts_pkg::PH_IDLE)
    else $error("transaction ended but sequencer not idle");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("request consumed without a result");
`endif

endmodule
